>>> src/sccbm_pkg.sv
// Shared types and constants of the SCCB register master.
// Holds the transfer payload structs, the bus phase codes and the register reset values.
// No dependencies.
package sccbm_pkg;

  // Configuration register indexes and reset values
  localparam logic CfgPhaseTicks    = 1'b0;
  localparam logic CfgWriteAttempts = 1'b1;
  localparam logic [15:0] PhaseTicksRst    = 16'd100;
  localparam logic [2:0]  WriteAttemptsRst = 3'd3;

  // Command codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_PROBE = 2'd2;

  // Bus phase codes
  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_S0        = 5'd1;
  localparam logic [4:0] PH_S1        = 5'd2;
  localparam logic [4:0] PH_S2        = 5'd3;
  localparam logic [4:0] PH_S3        = 5'd4;
  localparam logic [4:0] PH_TX_LOW    = 5'd5;
  localparam logic [4:0] PH_TX_HIGH   = 5'd6;
  localparam logic [4:0] PH_TX_END    = 5'd7;
  localparam logic [4:0] PH_ACK_LOW   = 5'd8;
  localparam logic [4:0] PH_ACK_HIGH  = 5'd9;
  localparam logic [4:0] PH_ACK_END   = 5'd10;
  localparam logic [4:0] PH_RX_LOW    = 5'd11;
  localparam logic [4:0] PH_RX_HIGH   = 5'd12;
  localparam logic [4:0] PH_MACK_LOW  = 5'd13;
  localparam logic [4:0] PH_MACK_HIGH = 5'd14;
  localparam logic [4:0] PH_MACK_END  = 5'd15;
  localparam logic [4:0] PH_STOP_A    = 5'd16;
  localparam logic [4:0] PH_STOP_B    = 5'd17;
  localparam logic [4:0] PH_STOP_C    = 5'd18;

  // One tick of input
  typedef struct packed {
    logic        cmd_valid;
    logic [1:0]  op;
    logic [6:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [15:0] write_data;
    logic        sda_in;
  } cmd_t;

  // One tick of output
  typedef struct packed {
    logic        scl;
    logic        sda_out;
    logic        sda_oe;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_result;
    logic        status;
  } res_t;

  // Sequencer state, including the latched command
  typedef struct packed {
    logic [4:0]  phase;
    logic [15:0] delay_count;
    logic [3:0]  bit_count;
    logic [2:0]  byte_index;
    logic [7:0]  shift_byte;
    logic [15:0] read_value;
    logic [2:0]  attempt_count;
    logic        nack_seen;
    logic [1:0]  lc_op;
    logic [6:0]  lc_dev;
    logic [7:0]  lc_reg;
    logic [15:0] lc_data;
  } st_t;

endpackage

>>> src/sccb_register_master.sv
// SCCB register master: one input transfer per bus tick, one result transfer per input.
// Latency: the result of a tick is registered and offered the cycle after it is accepted.
// Throughput: one tick per cycle while the result register can take it, set by the single state register st_q.
// Reset: bus sequencer idle, all state cleared, phase_ticks 100, write_attempts 3,
// result register empty.
// Depends on sccbm_pkg, sccbm_step and sccbm_out_reg.
module sccb_register_master (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sccbm_pkg::cmd_t in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sccbm_pkg::res_t out_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [15:0]     cfg_wdata_i
);

  logic [15:0]     phase_ticks_q;
  logic [2:0]      write_attempts_q;
  sccbm_pkg::st_t  st_q;
  sccbm_pkg::st_t  st_d;
  sccbm_pkg::res_t res;
  logic            in_fire;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q    <= sccbm_pkg::PhaseTicksRst;
      write_attempts_q <= sccbm_pkg::WriteAttemptsRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == sccbm_pkg::CfgPhaseTicks) phase_ticks_q <= cfg_wdata_i;
      else if (cfg_idx_i == sccbm_pkg::CfgWriteAttempts) write_attempts_q <= cfg_wdata_i[2:0];
    end
  end

  // Tick logic
  sccbm_step u_step (
    .st_i             (st_q),
    .cmd_i            (in_i),
    .phase_ticks_i    (phase_ticks_q),
    .write_attempts_i (write_attempts_q),
    .st_o             (st_d),
    .res_o            (res)
  );

  assign in_fire = in_valid_i && in_ready_o;

  // Advance the sequencer on each accepted transfer; all-zero state is idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (in_fire) begin
      st_q <= st_d;
    end
  end

  // Result register
  sccbm_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_fire),
    .data_i     (res),
    .can_load_o (in_ready_o),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .data_o     (out_o)
  );

endmodule

>>> src/sccbm_step.sv
// Next-state and line-level logic for one tick of the SCCB register master.
// Purely combinational; uses sccbm_pkg for the state, payload types and phase codes.
module sccbm_step (
  input  sccbm_pkg::st_t  st_i,
  input  sccbm_pkg::cmd_t cmd_i,
  input  logic [15:0]     phase_ticks_i,
  input  logic [2:0]      write_attempts_i,
  output sccbm_pkg::st_t  st_o,
  output sccbm_pkg::res_t res_o
);

  // Pick the byte to shift out for the given byte slot
  function automatic logic [7:0] tx_byte(input logic [1:0] op, input logic [2:0] idx,
                                         input logic [6:0] dev, input logic [7:0] reg_a,
                                         input logic [15:0] data);
    logic [7:0] b;
    if (idx == 3'd0) b = {dev, 1'b0};
    else if (op == sccbm_pkg::OP_READ && idx == 3'd2) b = {dev, 1'b1};
    else if (idx == 3'd1) b = reg_a;
    else if (idx == 3'd2) b = data[15:8];
    else b = data[7:0];
    return b;
  endfunction

  always_comb begin
    sccbm_pkg::st_t n;
    logic           nack;
    logic [7:0]     sb;
    logic           scl;
    logic           sdo;
    logic           oe;
    logic           busy;
    logic           done;

    n    = st_i;
    nack = 1'b0;
    sb   = 8'h00;
    scl  = 1'b1;
    sdo  = 1'b1;
    oe   = 1'b0;
    busy = 1'b0;
    done = 1'b0;

    // Take a new command when idle and its op is write, read or probe
    if (n.phase == sccbm_pkg::PH_IDLE && cmd_i.cmd_valid && cmd_i.op <= sccbm_pkg::OP_PROBE) begin
      n.lc_op         = cmd_i.op;
      n.lc_dev        = cmd_i.dev_addr;
      n.lc_reg        = cmd_i.reg_addr;
      n.lc_data       = cmd_i.write_data;
      n.delay_count   = 16'd0;
      n.bit_count     = 4'd0;
      n.byte_index    = 3'd0;
      n.shift_byte    = 8'h00;
      n.attempt_count = 3'd1;
      n.nack_seen     = 1'b0;
      n.phase         = sccbm_pkg::PH_S1;
    end

    // Drive the line levels of the current phase
    unique case (n.phase)
      sccbm_pkg::PH_S0: begin scl = 1'b0; sdo = 1'b1; oe = 1'b1; end
      sccbm_pkg::PH_S1: begin scl = 1'b1; sdo = 1'b1; oe = 1'b1; end
      sccbm_pkg::PH_S2: begin scl = 1'b1; sdo = 1'b0; oe = 1'b1; end
      sccbm_pkg::PH_S3: begin scl = 1'b0; sdo = 1'b0; oe = 1'b1; end
      sccbm_pkg::PH_TX_LOW, sccbm_pkg::PH_TX_END: begin
        scl = 1'b0; sdo = n.shift_byte[7]; oe = 1'b1;
      end
      sccbm_pkg::PH_TX_HIGH: begin scl = 1'b1; sdo = n.shift_byte[7]; oe = 1'b1; end
      sccbm_pkg::PH_ACK_LOW, sccbm_pkg::PH_ACK_END, sccbm_pkg::PH_RX_LOW: scl = 1'b0;
      sccbm_pkg::PH_ACK_HIGH, sccbm_pkg::PH_RX_HIGH: scl = 1'b1;
      sccbm_pkg::PH_MACK_LOW, sccbm_pkg::PH_MACK_END: begin
        scl = 1'b0; sdo = (n.byte_index != 3'd3); oe = 1'b1;
      end
      sccbm_pkg::PH_MACK_HIGH: begin
        scl = 1'b1; sdo = (n.byte_index != 3'd3); oe = 1'b1;
      end
      sccbm_pkg::PH_STOP_A: begin scl = 1'b0; sdo = 1'b0; oe = 1'b1; end
      sccbm_pkg::PH_STOP_B: begin scl = 1'b1; sdo = 1'b0; oe = 1'b1; end
      sccbm_pkg::PH_STOP_C: begin scl = 1'b1; sdo = 1'b1; oe = 1'b1; end
      default: ;
    endcase

    // Count the ticks of the phase and advance at its end
    if (n.phase != sccbm_pkg::PH_IDLE) begin
      busy = 1'b1;
      if ({1'b0, n.delay_count} + 17'd1 >= {1'b0, phase_ticks_i}) begin
        n.delay_count = 16'd0;
        unique case (n.phase)
          sccbm_pkg::PH_S0: n.phase = sccbm_pkg::PH_S1;
          sccbm_pkg::PH_S1: n.phase = sccbm_pkg::PH_S2;
          sccbm_pkg::PH_S2: n.phase = sccbm_pkg::PH_S3;
          sccbm_pkg::PH_S3: begin
            n.shift_byte = tx_byte(n.lc_op, n.byte_index, n.lc_dev, n.lc_reg, n.lc_data);
            n.bit_count  = 4'd0;
            n.phase      = sccbm_pkg::PH_TX_LOW;
          end
          sccbm_pkg::PH_TX_LOW:  n.phase = sccbm_pkg::PH_TX_HIGH;
          sccbm_pkg::PH_TX_HIGH: n.phase = sccbm_pkg::PH_TX_END;
          sccbm_pkg::PH_TX_END: begin
            n.shift_byte = {n.shift_byte[6:0], 1'b0};
            n.bit_count  = 4'(n.bit_count + 4'd1);
            n.phase      = (n.bit_count >= 4'd8) ? sccbm_pkg::PH_ACK_LOW : sccbm_pkg::PH_TX_LOW;
          end
          sccbm_pkg::PH_ACK_LOW: n.phase = sccbm_pkg::PH_ACK_HIGH;
          sccbm_pkg::PH_ACK_HIGH: begin
            n.shift_byte = {7'd0, cmd_i.sda_in};
            n.phase      = sccbm_pkg::PH_ACK_END;
          end
          sccbm_pkg::PH_ACK_END: begin
            nack = n.shift_byte[0];
            if (n.lc_op == sccbm_pkg::OP_WRITE) begin
              // High data byte ignores its ack; other NACKs retry or give up
              if (n.byte_index == 3'd2) begin
                n.byte_index = 3'd3;
                n.shift_byte = tx_byte(n.lc_op, n.byte_index, n.lc_dev, n.lc_reg, n.lc_data);
                n.bit_count  = 4'd0;
                n.phase      = sccbm_pkg::PH_TX_LOW;
              end else if (nack) begin
                if (n.attempt_count < write_attempts_i) begin
                  n.attempt_count = 3'(n.attempt_count + 3'd1);
                  n.byte_index    = 3'd0;
                  n.phase         = sccbm_pkg::PH_S0;
                end else begin
                  n.nack_seen = 1'b1;
                  n.phase     = sccbm_pkg::PH_STOP_A;
                end
              end else if (n.byte_index == 3'd3) begin
                n.phase = sccbm_pkg::PH_STOP_A;
              end else begin
                n.byte_index = 3'(n.byte_index + 3'd1);
                n.shift_byte = tx_byte(n.lc_op, n.byte_index, n.lc_dev, n.lc_reg, n.lc_data);
                n.bit_count  = 4'd0;
                n.phase      = sccbm_pkg::PH_TX_LOW;
              end
            end else if (n.lc_op == sccbm_pkg::OP_READ) begin
              if (nack) n.nack_seen = 1'b1;
              if (n.byte_index == 3'd0) begin
                n.byte_index = 3'd1;
                n.shift_byte = tx_byte(n.lc_op, n.byte_index, n.lc_dev, n.lc_reg, n.lc_data);
                n.bit_count  = 4'd0;
                n.phase      = sccbm_pkg::PH_TX_LOW;
              end else if (n.byte_index == 3'd1) begin
                n.byte_index = 3'd2;
                n.phase      = sccbm_pkg::PH_S0;
              end else begin
                n.byte_index = 3'd3;
                n.bit_count  = 4'd0;
                n.shift_byte = 8'h00;
                n.phase      = sccbm_pkg::PH_RX_LOW;
              end
            end else begin
              n.nack_seen = nack;
              n.phase     = sccbm_pkg::PH_STOP_A;
            end
          end
          sccbm_pkg::PH_RX_LOW: n.phase = sccbm_pkg::PH_RX_HIGH;
          sccbm_pkg::PH_RX_HIGH: begin
            sb           = {n.shift_byte[6:0], cmd_i.sda_in};
            n.shift_byte = sb;
            n.bit_count  = 4'(n.bit_count + 4'd1);
            if (n.bit_count >= 4'd8) begin
              // First byte parks in the data field, second completes the value
              if (n.byte_index == 3'd3) n.lc_data = {sb, 8'h00};
              else n.read_value = {n.lc_data[15:8], sb};
              n.phase = sccbm_pkg::PH_MACK_LOW;
            end else begin
              n.phase = sccbm_pkg::PH_RX_LOW;
            end
          end
          sccbm_pkg::PH_MACK_LOW:  n.phase = sccbm_pkg::PH_MACK_HIGH;
          sccbm_pkg::PH_MACK_HIGH: n.phase = sccbm_pkg::PH_MACK_END;
          sccbm_pkg::PH_MACK_END: begin
            if (n.byte_index == 3'd3) begin
              n.byte_index = 3'd4;
              n.bit_count  = 4'd0;
              n.shift_byte = 8'h00;
              n.phase      = sccbm_pkg::PH_RX_LOW;
            end else begin
              n.phase = sccbm_pkg::PH_STOP_A;
            end
          end
          sccbm_pkg::PH_STOP_A: n.phase = sccbm_pkg::PH_STOP_B;
          sccbm_pkg::PH_STOP_B: n.phase = sccbm_pkg::PH_STOP_C;
          sccbm_pkg::PH_STOP_C: begin
            n.phase = sccbm_pkg::PH_IDLE;
            done    = 1'b1;
          end
          default: n.phase = sccbm_pkg::PH_IDLE;
        endcase
      end else begin
        n.delay_count = 16'(n.delay_count + 16'd1);
      end
    end

    st_o              = n;
    res_o.scl         = scl;
    res_o.sda_out     = sdo;
    res_o.sda_oe      = oe;
    res_o.busy_res    = busy;
    res_o.done_res    = done;
    res_o.read_result = n.read_value;
    res_o.status      = n.nack_seen;
  end

endmodule

>>> src/sccbm_out_reg.sv
// Result register of the SCCB register master with valid/ready towards the consumer.
// Uses sccbm_pkg for the result payload type.
module sccbm_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  sccbm_pkg::res_t data_i,
  output logic            can_load_o,
  output logic            valid_o,
  input  logic            ready_i,
  output sccbm_pkg::res_t data_o
);

  logic            valid_q;
  logic            valid_d;
  sccbm_pkg::res_t data_q;

  // Free when empty or when the held result leaves this cycle
  assign can_load_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (ready_i) valid_d = 1'b0;
  end

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload on load
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
